/* hw/rtl/outline_to_cubic_path_converter_core_defines.svh */
// ----------------------------------------------------------------------------
// outline_to_cubic_path_converter_core defines
// assertion macros shared by the checker of the path converter
// ----------------------------------------------------------------------------
`ifndef OUTLINE_TO_CUBIC_PATH_CONVERTER_CORE_DEFINES_SVH
`define OUTLINE_TO_CUBIC_PATH_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication
`define O2C_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("o2c assertion failed");

// next-cycle implication
`define O2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("o2c assertion failed");

`endif

/* hw/rtl/o2c_pkg.sv */
// ----------------------------------------------------------------------------
// o2c_pkg
// types, constants and codes of the outline to cubic path converter
// ----------------------------------------------------------------------------
package o2c_pkg;

    localparam int C_COORD_BITS    = 24;
    localparam int C_PENDING_DEPTH = 8;
    localparam int C_HOLD_POINTS   = 4;
    localparam int C_COUNT_BITS    = $clog2(C_PENDING_DEPTH + 1);
    localparam int C_IDX_BITS      = $clog2(C_PENDING_DEPTH);
    localparam int C_NUM_BITS      = C_COORD_BITS + 2;
    localparam int C_DIV_SHIFT     = C_COORD_BITS + 3 + ((C_COORD_BITS + 4) % 2);
    localparam int C_PROD_BITS     = C_NUM_BITS + C_DIV_SHIFT;
    localparam logic [C_DIV_SHIFT-1:0] C_RECIP3 =
        C_DIV_SHIFT'(((64'd1 << C_DIV_SHIFT) + 64'd1) / 64'd3);

    localparam logic [2:0] OP_MOVE   = 3'd0;
    localparam logic [2:0] OP_LINE   = 3'd1;
    localparam logic [2:0] OP_CONIC  = 3'd2;
    localparam logic [2:0] OP_CUBIC  = 3'd3;
    localparam logic [2:0] OP_FINISH = 3'd4;

    localparam logic [1:0] KIND_MOVE  = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_CURVE = 2'd2;

    typedef logic signed [C_COORD_BITS-1:0] t_coord;
    typedef logic signed [C_COORD_BITS:0]   t_wide;
    typedef logic signed [C_NUM_BITS-1:0]   t_num;
    typedef logic [C_PROD_BITS-1:0]         t_prod;
    typedef logic [C_COUNT_BITS-1:0]        t_count;

    typedef struct packed {
        logic [2:0] opcode;
        t_coord     x1;
        t_coord     y1;
        t_coord     x2;
        t_coord     y2;
        t_coord     x3;
        t_coord     y3;
    } t_in_item;

    typedef struct packed {
        t_coord     point_x;
        t_coord     point_y;
        logic [1:0] point_kind;
        logic       close_figure;
        logic       path_empty;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        t_coord     x;
        t_coord     y;
        logic [1:0] kind;
        logic       closed;
    } t_point;

    typedef enum logic [1:0] {
        SRC_A,
        SRC_B,
        SRC_C,
        SRC_DIV
    } t_push_src;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PUSH_A,
        ST_PUSH_B,
        ST_PUSH_C,
        ST_DIV1,
        ST_WAIT1,
        ST_DIV2,
        ST_WAIT2,
        ST_DRAIN,
        ST_MARK
    } t_state;

    typedef struct packed {
        logic      load;
        logic      check;
        logic      push;
        t_push_src push_src;
        logic      set_cur;
        logic      div_start;
        logic      div_second;
        logic      drain;
        logic      drain_last;
        logic      marker;
    } t_dp_cmd;

    typedef struct packed {
        t_count count;
        logic   out_free;
        logic   div_done;
    } t_dp_status;

endpackage

/* hw/rtl/o2c_div3.sv */
// ----------------------------------------------------------------------------
// o2c_div3
// four-stage base plus truncated third of a signed numerator
// ----------------------------------------------------------------------------
module o2c_div3 (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  o2c_pkg::t_num         i_num,
    input  o2c_pkg::t_coord       i_base,
    output logic                  o_done,
    output o2c_pkg::t_coord       o_result
);

    logic                                   r_v1, r_v2, r_v3, r_v4;
    o2c_pkg::t_num                          r_num;
    o2c_pkg::t_coord                        r_base1, r_base2, r_base3;
    logic [o2c_pkg::C_NUM_BITS-1:0]         r_mag2;
    logic                                   r_neg2, r_neg3;
    o2c_pkg::t_prod                         r_prod;
    o2c_pkg::t_coord                        r_res;
    logic [o2c_pkg::C_COORD_BITS-1:0]       w_q;
    o2c_pkg::t_wide                         w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign w_q   = r_prod[o2c_pkg::C_DIV_SHIFT +: o2c_pkg::C_COORD_BITS];
    assign w_sum = r_neg3 ? o2c_pkg::t_wide'(r_base3) - o2c_pkg::t_wide'({1'b0, w_q})
                          : o2c_pkg::t_wide'(r_base3) + o2c_pkg::t_wide'({1'b0, w_q});

    always_ff @(posedge i_clk) begin
        r_num   <= i_num;
        r_base1 <= i_base;
        r_neg2  <= r_num[o2c_pkg::C_NUM_BITS-1];
        r_mag2  <= r_num[o2c_pkg::C_NUM_BITS-1] ? -r_num : r_num;
        r_base2 <= r_base1;
        r_neg3  <= r_neg2;
        r_prod  <= o2c_pkg::t_prod'(r_mag2) * o2c_pkg::t_prod'(o2c_pkg::C_RECIP3);
        r_base3 <= r_base2;
        r_res   <= w_sum[o2c_pkg::C_COORD_BITS-1:0];
    end

    assign o_done   = r_v4;
    assign o_result = r_res;

endmodule

/* hw/rtl/o2c_datapath.sv */
// ----------------------------------------------------------------------------
// o2c_datapath
// item register, pending point window, current point, conic thirds and
// output register of the path converter
// ----------------------------------------------------------------------------
module o2c_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  o2c_pkg::t_in_item     i_in_data,
    input  o2c_pkg::t_dp_cmd      i_cmd,
    output o2c_pkg::t_dp_status   o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output o2c_pkg::t_out_item    o_out_data
);

    o2c_pkg::t_in_item              r_item;
    o2c_pkg::t_coord                r_cur_x, r_cur_y, n_cur_x, n_cur_y;
    o2c_pkg::t_point                r_win [o2c_pkg::C_PENDING_DEPTH];
    o2c_pkg::t_point                n_win [o2c_pkg::C_PENDING_DEPTH];
    o2c_pkg::t_count                r_count, n_count;
    logic                           r_any, n_any;
    o2c_pkg::t_out_item             r_out;
    logic                           r_out_valid;

    o2c_pkg::t_wide                 w_dx, w_dy;
    o2c_pkg::t_num                  w_num_x, w_num_y;
    o2c_pkg::t_coord                w_base_x, w_base_y;
    logic                           w_done_x, w_done_y;
    o2c_pkg::t_coord                w_div_x, w_div_y;
    o2c_pkg::t_point                w_new;
    o2c_pkg::t_count                w_tail;
    logic [o2c_pkg::C_IDX_BITS-1:0] w_tail_idx;
    logic                           w_drop2, w_drop4;

    // conic thirds
    always_comb begin
        if (i_cmd.div_second) begin
            w_dx     = o2c_pkg::t_wide'(r_item.x2) - o2c_pkg::t_wide'(r_item.x1);
            w_dy     = o2c_pkg::t_wide'(r_item.y2) - o2c_pkg::t_wide'(r_item.y1);
            w_num_x  = o2c_pkg::t_num'(w_dx);
            w_num_y  = o2c_pkg::t_num'(w_dy);
            w_base_x = r_item.x1;
            w_base_y = r_item.y1;
        end else begin
            w_dx     = o2c_pkg::t_wide'(r_item.x1) - o2c_pkg::t_wide'(r_cur_x);
            w_dy     = o2c_pkg::t_wide'(r_item.y1) - o2c_pkg::t_wide'(r_cur_y);
            w_num_x  = $signed({w_dx, 1'b0});
            w_num_y  = $signed({w_dy, 1'b0});
            w_base_x = r_cur_x;
            w_base_y = r_cur_y;
        end
    end

    o2c_div3 u_div_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_start),
        .i_num    (w_num_x),
        .i_base   (w_base_x),
        .o_done   (w_done_x),
        .o_result (w_div_x)
    );

    o2c_div3 u_div_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_start),
        .i_num    (w_num_y),
        .i_base   (w_base_y),
        .o_done   (w_done_y),
        .o_result (w_div_y)
    );

    // point to push
    always_comb begin
        w_new.closed = 1'b0;
        w_new.kind   = o2c_pkg::KIND_CURVE;
        case (i_cmd.push_src)
            o2c_pkg::SRC_A: begin
                w_new.x = r_item.x1;
                w_new.y = r_item.y1;
                if (r_item.opcode == o2c_pkg::OP_MOVE) begin
                    w_new.kind = o2c_pkg::KIND_MOVE;
                end else if (r_item.opcode == o2c_pkg::OP_LINE) begin
                    w_new.kind = o2c_pkg::KIND_LINE;
                end
            end
            o2c_pkg::SRC_B: begin
                w_new.x = r_item.x2;
                w_new.y = r_item.y2;
            end
            o2c_pkg::SRC_C: begin
                w_new.x = r_item.x3;
                w_new.y = r_item.y3;
            end
            default: begin
                w_new.x = w_div_x;
                w_new.y = w_div_y;
            end
        endcase
    end

    // degenerate contour tests, newest point at index 0
    assign w_drop2 = (r_count >= o2c_pkg::C_COUNT_BITS'(2))
                   && r_win[1].kind == o2c_pkg::KIND_MOVE && !r_win[1].closed
                   && r_win[1].x == r_win[0].x && r_win[1].y == r_win[0].y;
    assign w_drop4 = (r_count >= o2c_pkg::C_COUNT_BITS'(4))
                   && r_win[3].kind == o2c_pkg::KIND_MOVE && !r_win[3].closed
                   && r_win[2].kind == o2c_pkg::KIND_CURVE && !r_win[2].closed
                   && r_win[2].x == r_win[3].x && r_win[2].y == r_win[3].y
                   && r_win[1].x == r_win[3].x && r_win[1].y == r_win[3].y
                   && r_win[0].x == r_win[3].x && r_win[0].y == r_win[3].y;

    assign w_tail     = o2c_pkg::t_count'(r_count - o2c_pkg::C_COUNT_BITS'(1));
    assign w_tail_idx = w_tail[o2c_pkg::C_IDX_BITS-1:0];

    always_comb begin
        n_win   = r_win;
        n_count = r_count;
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_any   = r_any;
        if (i_cmd.check) begin
            if (w_drop2) begin
                for (int i = 0; i < o2c_pkg::C_PENDING_DEPTH - 2; i++) begin
                    n_win[i] = r_win[i + 2];
                end
                n_count = o2c_pkg::t_count'(r_count - o2c_pkg::C_COUNT_BITS'(2));
            end else if (w_drop4) begin
                for (int i = 0; i < o2c_pkg::C_PENDING_DEPTH - 4; i++) begin
                    n_win[i] = r_win[i + 4];
                end
                n_count = o2c_pkg::t_count'(r_count - o2c_pkg::C_COUNT_BITS'(4));
            end
            if (n_count != '0) begin
                n_win[0].closed = 1'b1;
            end
        end else if (i_cmd.push) begin
            if (r_count < o2c_pkg::C_COUNT_BITS'(o2c_pkg::C_PENDING_DEPTH)) begin
                for (int i = 1; i < o2c_pkg::C_PENDING_DEPTH; i++) begin
                    n_win[i] = r_win[i - 1];
                end
                n_win[0] = w_new;
                n_count  = o2c_pkg::t_count'(r_count + o2c_pkg::C_COUNT_BITS'(1));
            end
            if (i_cmd.set_cur) begin
                n_cur_x = w_new.x;
                n_cur_y = w_new.y;
            end
        end else if (i_cmd.drain) begin
            n_count = w_tail;
            n_any   = 1'b1;
        end else if (i_cmd.marker) begin
            n_count = '0;
            n_cur_x = '0;
            n_cur_y = '0;
            n_any   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_any   <= n_any;
            if (i_cmd.drain || i_cmd.marker) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.drain) begin
            r_out.point_x      <= r_win[w_tail_idx].x;
            r_out.point_y      <= r_win[w_tail_idx].y;
            r_out.point_kind   <= r_win[w_tail_idx].kind;
            r_out.close_figure <= r_win[w_tail_idx].closed;
            r_out.path_empty   <= 1'b0;
            r_out.last_of_run  <= i_cmd.drain_last;
        end else if (i_cmd.marker) begin
            r_out.point_x      <= '0;
            r_out.point_y      <= '0;
            r_out.point_kind   <= o2c_pkg::KIND_MOVE;
            r_out.close_figure <= 1'b0;
            r_out.path_empty   <= !r_any;
            r_out.last_of_run  <= 1'b1;
        end
    end

    assign o_status.count    = r_count;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.div_done = w_done_x && w_done_y;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

/* hw/rtl/o2c_ctrl.sv */
// ----------------------------------------------------------------------------
// o2c_ctrl
// sequencer of the path converter: check, push, conic thirds, drain, marker
// ----------------------------------------------------------------------------
module o2c_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_opcode,
    input  o2c_pkg::t_dp_status   i_status,
    output o2c_pkg::t_dp_cmd      o_cmd
);

    o2c_pkg::t_state  r_state, n_state;
    logic [2:0]       r_op, n_op;
    logic             w_fin;
    o2c_pkg::t_count  w_keep, w_keep_p1;

    assign w_fin     = (r_op == o2c_pkg::OP_FINISH);
    assign w_keep    = w_fin ? '0 : o2c_pkg::C_COUNT_BITS'(o2c_pkg::C_HOLD_POINTS);
    assign w_keep_p1 = o2c_pkg::t_count'(w_keep + o2c_pkg::C_COUNT_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= o2c_pkg::ST_IDLE;
            r_op    <= o2c_pkg::OP_MOVE;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_op             = r_op;
        o_in_ready       = 1'b0;
        o_cmd.load       = 1'b0;
        o_cmd.check      = 1'b0;
        o_cmd.push       = 1'b0;
        o_cmd.push_src   = o2c_pkg::SRC_A;
        o_cmd.set_cur    = 1'b0;
        o_cmd.div_start  = 1'b0;
        o_cmd.div_second = 1'b0;
        o_cmd.drain      = 1'b0;
        o_cmd.drain_last = 1'b0;
        o_cmd.marker     = 1'b0;
        case (r_state)
            o2c_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_op       = i_opcode;
                    case (i_opcode)
                        o2c_pkg::OP_MOVE, o2c_pkg::OP_FINISH: n_state = o2c_pkg::ST_CHECK;
                        o2c_pkg::OP_LINE, o2c_pkg::OP_CUBIC:  n_state = o2c_pkg::ST_PUSH_A;
                        o2c_pkg::OP_CONIC:                    n_state = o2c_pkg::ST_DIV1;
                        default:                              n_state = o2c_pkg::ST_IDLE;
                    endcase
                end
            end
            o2c_pkg::ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = w_fin ? o2c_pkg::ST_DRAIN : o2c_pkg::ST_PUSH_A;
            end
            o2c_pkg::ST_PUSH_A: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_src = o2c_pkg::SRC_A;
                o_cmd.set_cur  = (r_op != o2c_pkg::OP_CUBIC);
                n_state = (r_op == o2c_pkg::OP_CUBIC) ? o2c_pkg::ST_PUSH_B : o2c_pkg::ST_DRAIN;
            end
            o2c_pkg::ST_PUSH_B: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_src = o2c_pkg::SRC_B;
                o_cmd.set_cur  = (r_op == o2c_pkg::OP_CONIC);
                n_state = (r_op == o2c_pkg::OP_CUBIC) ? o2c_pkg::ST_PUSH_C : o2c_pkg::ST_DRAIN;
            end
            o2c_pkg::ST_PUSH_C: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_src = o2c_pkg::SRC_C;
                o_cmd.set_cur  = 1'b1;
                n_state        = o2c_pkg::ST_DRAIN;
            end
            o2c_pkg::ST_DIV1: begin
                o_cmd.div_start = 1'b1;
                n_state         = o2c_pkg::ST_WAIT1;
            end
            o2c_pkg::ST_WAIT1: begin
                if (i_status.div_done) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_src = o2c_pkg::SRC_DIV;
                    n_state        = o2c_pkg::ST_DIV2;
                end
            end
            o2c_pkg::ST_DIV2: begin
                o_cmd.div_start  = 1'b1;
                o_cmd.div_second = 1'b1;
                n_state          = o2c_pkg::ST_WAIT2;
            end
            o2c_pkg::ST_WAIT2: begin
                o_cmd.div_second = 1'b1;
                if (i_status.div_done) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_src = o2c_pkg::SRC_DIV;
                    n_state        = o2c_pkg::ST_PUSH_B;
                end
            end
            o2c_pkg::ST_DRAIN: begin
                if (i_status.count > w_keep) begin
                    if (i_status.out_free) begin
                        o_cmd.drain      = 1'b1;
                        o_cmd.drain_last = !w_fin && (i_status.count == w_keep_p1);
                        if (i_status.count == w_keep_p1) begin
                            n_state = w_fin ? o2c_pkg::ST_MARK : o2c_pkg::ST_IDLE;
                        end
                    end
                end else begin
                    n_state = w_fin ? o2c_pkg::ST_MARK : o2c_pkg::ST_IDLE;
                end
            end
            o2c_pkg::ST_MARK: begin
                if (i_status.out_free) begin
                    o_cmd.marker = 1'b1;
                    n_state      = o2c_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = o2c_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/outline_to_cubic_path_converter_core.sv */
// ----------------------------------------------------------------------------
// outline_to_cubic_path_converter_core
// glyph outline commands in, closed cubic path points out
// ----------------------------------------------------------------------------
// Input beats (i_in_valid / o_in_ready) carry one outline command; output
// beats (o_out_valid / i_out_ready) carry one path point or the finish marker.
// One command is worked at a time; o_in_ready is high only while idle.
// A conic makes two passes through the four-stage third unit. A finish command
// sends every pending point and then the marker beat; a bad opcode is taken
// and dropped.
// Move, line, conic and cubic commands send the points that fall out of the
// four-point tail of the pending window, one per cycle while the output is
// free; the first is loaded into the output register from the drain state
// that follows the last push.
// The output register keeps a beat while i_out_ready is low and the sequencer
// waits on it; the pending window itself never overflows.
// Synchronous reset empties the window, clears the current point and the
// output valid flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module outline_to_cubic_path_converter_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  o2c_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output o2c_pkg::t_out_item    o_out_data
);

    o2c_pkg::t_dp_cmd     w_cmd;
    o2c_pkg::t_dp_status  w_status;

    o2c_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_opcode   (i_in_data.opcode),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    o2c_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* hw/rtl/o2c_checker.sv */
// ----------------------------------------------------------------------------
// o2c_checker
// port-level checks of the path converter, bound to the top level
// ----------------------------------------------------------------------------
`include "outline_to_cubic_path_converter_core_defines.svh"

module o2c_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  o2c_pkg::t_in_item     i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  o2c_pkg::t_out_item    i_out_data
);

    `O2C_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    `O2C_ASSERT_NEXT(a_busy_after_cmd, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_data.opcode == o2c_pkg::OP_MOVE || i_in_data.opcode == o2c_pkg::OP_LINE || i_in_data.opcode == o2c_pkg::OP_CONIC || i_in_data.opcode == o2c_pkg::OP_CUBIC || i_in_data.opcode == o2c_pkg::OP_FINISH), !i_in_ready)

    `O2C_ASSERT_NOW(a_empty_marker, i_clk, i_rst_n, i_out_valid && i_out_data.path_empty, i_out_data.point_x == '0 && i_out_data.point_y == '0 && i_out_data.last_of_run && !i_out_data.close_figure)

endmodule

bind outline_to_cubic_path_converter_core o2c_checker u_o2c_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
